[rtl/hbed_pkg.sv]
// ----------------------------------------------------------------------------
// hbed_pkg
// Types, codes and constants shared by the Huffman build, encode and decode
// block.
// ----------------------------------------------------------------------------
package hbed_pkg;

	localparam int ALPHABET_SIZE_DEF = 256;
	localparam int MAX_TEXT_LEN_DEF  = 65535;
	localparam int NODE_IW           = 9;
	localparam int WEIGHT_W          = 16;
	localparam int CODE_W            = 32;
	localparam int LEN_W             = 6;
	localparam int SIZE_W            = 21;

	localparam logic [2:0] KIND_COUNT  = 3'd0;
	localparam logic [2:0] KIND_BUILD  = 3'd1;
	localparam logic [2:0] KIND_ENCODE = 3'd2;
	localparam logic [2:0] KIND_DECODE = 3'd3;
	localparam logic [2:0] KIND_CLEAR  = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_TREE = 2'd1;
	localparam logic [1:0] ST_NO_CODE = 2'd2;
	localparam logic [1:0] ST_LIMIT   = 2'd3;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] symbol;
		logic       coded_bit;
	} in_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [CODE_W-1:0] code_word;
		logic [LEN_W-1:0]  code_length;
		logic [7:0]        decoded_symbol;
		logic              symbol_valid;
		logic [8:0]        distinct_symbols;
		logic [SIZE_W-1:0] encoded_size_bits;
	} out_t;

	typedef struct packed {
		logic                live;
		logic [NODE_IW-1:0]  right;
		logic [NODE_IW-1:0]  left;
		logic [WEIGHT_W-1:0] weight;
	} node_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} code_t;

	typedef enum logic [4:0] {
		OP_IDLE, OP_CNT_RD, OP_CNT_WR, OP_ENC_RD, OP_ENC_FIN, OP_DEC_RD,
		OP_DEC_STEP, OP_DEC_LEAF, OP_DEC_FIN, OP_CLR, OP_NOP, OP_B_START,
		OP_B_EMPTY, OP_GATH, OP_MCHK, OP_SCAN, OP_TAKE, OP_MERGE, OP_CSINGLE,
		OP_CROOT, OP_CRD, OP_CWA, OP_CWB, OP_LRD, OP_LWR, OP_B_FIN
	} op_t;

	typedef struct packed {
		logic accept;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic total_zero;
		logic gath_done;
		logic merge_more;
		logic single_leaf;
		logic scan_done;
		logic pass;
		logic code_last;
		logic leaf_last;
		logic dec_to_leaf;
	} sts_t;

endpackage

[rtl/hbed_ram.sv]
// ----------------------------------------------------------------------------
// hbed_ram
// Simple dual-port RAM, one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module hbed_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/hbed_ctrl.sv]
// ----------------------------------------------------------------------------
// hbed_ctrl
// Sequencer for count, encode, decode, clear and the multi-phase tree build.
// ----------------------------------------------------------------------------
module hbed_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [2:0]         in_kind,
	output logic               in_ready,
	input  hbed_pkg::sts_t     sts,
	output hbed_pkg::cmd_t     cmd
);

	localparam int NS = 26;

	typedef enum logic [NS-1:0] {
		S_IDLE     = NS'(1) << 0,
		S_CNT_RD   = NS'(1) << 1,
		S_CNT_WR   = NS'(1) << 2,
		S_ENC_RD   = NS'(1) << 3,
		S_ENC_FIN  = NS'(1) << 4,
		S_DEC_RD   = NS'(1) << 5,
		S_DEC_STEP = NS'(1) << 6,
		S_DEC_LEAF = NS'(1) << 7,
		S_DEC_FIN  = NS'(1) << 8,
		S_CLR      = NS'(1) << 9,
		S_NOP      = NS'(1) << 10,
		S_B_START  = NS'(1) << 11,
		S_B_EMPTY  = NS'(1) << 12,
		S_GATH     = NS'(1) << 13,
		S_MCHK     = NS'(1) << 14,
		S_SCAN     = NS'(1) << 15,
		S_TAKE     = NS'(1) << 16,
		S_MERGE    = NS'(1) << 17,
		S_CSINGLE  = NS'(1) << 18,
		S_CROOT    = NS'(1) << 19,
		S_CRD      = NS'(1) << 20,
		S_CWA      = NS'(1) << 21,
		S_CWB      = NS'(1) << 22,
		S_LRD      = NS'(1) << 23,
		S_LWR      = NS'(1) << 24,
		S_B_FIN    = NS'(1) << 25
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d    = state_q;
		cmd.accept = in_ready && in_valid;
		cmd.op     = hbed_pkg::OP_IDLE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (in_kind)
						hbed_pkg::KIND_COUNT:  state_d = S_CNT_RD;
						hbed_pkg::KIND_BUILD:  state_d = S_B_START;
						hbed_pkg::KIND_ENCODE: state_d = S_ENC_RD;
						hbed_pkg::KIND_DECODE: state_d = S_DEC_RD;
						hbed_pkg::KIND_CLEAR:  state_d = S_CLR;
						default:               state_d = S_NOP;
					endcase
				end
			end
			S_CNT_RD: begin
				cmd.op  = hbed_pkg::OP_CNT_RD;
				state_d = S_CNT_WR;
			end
			S_CNT_WR: begin
				cmd.op = hbed_pkg::OP_CNT_WR;
				if (sts.out_free) state_d = S_IDLE;
			end
			S_ENC_RD: begin
				cmd.op  = hbed_pkg::OP_ENC_RD;
				state_d = S_ENC_FIN;
			end
			S_ENC_FIN: begin
				cmd.op = hbed_pkg::OP_ENC_FIN;
				if (sts.out_free) state_d = S_IDLE;
			end
			S_DEC_RD: begin
				cmd.op  = hbed_pkg::OP_DEC_RD;
				state_d = S_DEC_STEP;
			end
			S_DEC_STEP: begin
				cmd.op = hbed_pkg::OP_DEC_STEP;
				if (sts.dec_to_leaf) state_d = S_DEC_LEAF;
				else if (sts.out_free) state_d = S_IDLE;
			end
			S_DEC_LEAF: begin
				cmd.op  = hbed_pkg::OP_DEC_LEAF;
				state_d = S_DEC_FIN;
			end
			S_DEC_FIN: begin
				cmd.op = hbed_pkg::OP_DEC_FIN;
				if (sts.out_free) state_d = S_IDLE;
			end
			S_CLR: begin
				cmd.op = hbed_pkg::OP_CLR;
				if (sts.out_free) state_d = S_IDLE;
			end
			S_NOP: begin
				cmd.op = hbed_pkg::OP_NOP;
				if (sts.out_free) state_d = S_IDLE;
			end
			S_B_START: begin
				cmd.op  = hbed_pkg::OP_B_START;
				state_d = sts.total_zero ? S_B_EMPTY : S_GATH;
			end
			S_B_EMPTY: begin
				cmd.op = hbed_pkg::OP_B_EMPTY;
				if (sts.out_free) state_d = S_IDLE;
			end
			S_GATH: begin
				cmd.op = hbed_pkg::OP_GATH;
				if (sts.gath_done) state_d = S_MCHK;
			end
			S_MCHK: begin
				cmd.op = hbed_pkg::OP_MCHK;
				if (sts.merge_more) state_d = S_SCAN;
				else if (sts.single_leaf) state_d = S_CSINGLE;
				else state_d = S_CROOT;
			end
			S_SCAN: begin
				cmd.op = hbed_pkg::OP_SCAN;
				if (sts.scan_done) state_d = S_TAKE;
			end
			S_TAKE: begin
				cmd.op  = hbed_pkg::OP_TAKE;
				state_d = sts.pass ? S_MERGE : S_SCAN;
			end
			S_MERGE: begin
				cmd.op  = hbed_pkg::OP_MERGE;
				state_d = S_MCHK;
			end
			S_CSINGLE: begin
				cmd.op  = hbed_pkg::OP_CSINGLE;
				state_d = S_LRD;
			end
			S_CROOT: begin
				cmd.op  = hbed_pkg::OP_CROOT;
				state_d = S_CRD;
			end
			S_CRD: begin
				cmd.op  = hbed_pkg::OP_CRD;
				state_d = S_CWA;
			end
			S_CWA: begin
				cmd.op  = hbed_pkg::OP_CWA;
				state_d = S_CWB;
			end
			S_CWB: begin
				cmd.op  = hbed_pkg::OP_CWB;
				state_d = sts.code_last ? S_LRD : S_CRD;
			end
			S_LRD: begin
				cmd.op  = hbed_pkg::OP_LRD;
				state_d = S_LWR;
			end
			S_LWR: begin
				cmd.op  = hbed_pkg::OP_LWR;
				state_d = sts.leaf_last ? S_B_FIN : S_LRD;
			end
			S_B_FIN: begin
				cmd.op = hbed_pkg::OP_B_FIN;
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/hbed_dp.sv]
// ----------------------------------------------------------------------------
// hbed_dp
// Datapath: frequency, node, node-code and code-table memories, build scan
// registers, decode walker and the result register.
// ----------------------------------------------------------------------------
module hbed_dp #(
	parameter int ALPHABET_SIZE = hbed_pkg::ALPHABET_SIZE_DEF,
	parameter int MAX_TEXT_LEN  = hbed_pkg::MAX_TEXT_LEN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  hbed_pkg::in_t  in_data,
	input  hbed_pkg::cmd_t cmd,
	output hbed_pkg::sts_t sts,
	output logic           out_valid,
	input  logic           out_ready,
	output hbed_pkg::out_t out_data
);

	localparam int A   = ALPHABET_SIZE;
	localparam int SAW = $clog2(A);
	localparam int NN  = 2 * A - 1;
	localparam int NAW = $clog2(NN);
	localparam int IW  = hbed_pkg::NODE_IW;
	localparam int WW  = hbed_pkg::WEIGHT_W;

	hbed_pkg::in_t   item_q;
	logic [A-1:0]    cnt_vld_q, code_vld_q;
	logic [WW-1:0]   total_q;
	logic            tree_ready_q;
	logic [IW-1:0]   leaf_q, root_q, cursor_q, used_q, idx_q, next_q;
	logic            gv_q, sv_q, found_q, pass_q;
	logic [IW-1:0]   gidx_q, sidx_q, best_q, a_q;
	logic [WW-1:0]   best_w_q, a_w_q;
	logic [2*IW-1:0] best_ch_q;
	logic [hbed_pkg::SIZE_W-1:0] sum_q;
	hbed_pkg::out_t  out_q;
	logic            out_v_q;

	logic [WW-1:0]   cnt_rdata, cnt_wdata;
	logic            cnt_we;
	logic [SAW-1:0]  cnt_raddr;
	hbed_pkg::node_t node_rdata, node_wdata;
	logic            node_we;
	logic [IW-1:0]   node_waddr, node_raddr;
	hbed_pkg::code_t nc_rdata, nc_wdata, ct_rdata;
	logic            nc_we, ct_we;
	logic [IW-1:0]   nc_waddr;

	logic [SAW-1:0]  s;
	logic            sym_ok, cnt_full, out_free, single, res_load;
	logic [IW-1:0]   cur_eff, next;
	logic            next_leaf, gath_hit, going_leaf;
	logic [WW+hbed_pkg::LEN_W-1:0] prod;
	hbed_pkg::out_t  res;

	assign s         = item_q.symbol[SAW-1:0];
	assign sym_ok    = 9'(item_q.symbol) < 9'(A);
	assign cnt_full  = total_q >= WW'(MAX_TEXT_LEN);
	assign out_free  = !out_v_q || out_ready;
	assign single    = (leaf_q == 9'd1);
	assign next      = item_q.coded_bit ? node_rdata.right : node_rdata.left;
	assign next_leaf = next < leaf_q;
	assign gath_hit  = gv_q && cnt_vld_q[gidx_q[SAW-1:0]] && (cnt_rdata != '0);
	assign going_leaf = tree_ready_q && !single && next_leaf;
	assign prod      = node_rdata.weight * nc_rdata.len;

	always_comb begin
		if (single) cur_eff = '0;
		else if (cursor_q < leaf_q || cursor_q >= 9'(NN)) cur_eff = root_q;
		else cur_eff = cursor_q;
	end

	// Status back to the sequencer.
	always_comb begin
		sts.out_free    = out_free;
		sts.total_zero  = (total_q == '0);
		sts.gath_done   = (idx_q == 9'(A)) && !gv_q;
		sts.merge_more  = (10'(used_q) + 10'd1) < {leaf_q, 1'b0};
		sts.single_leaf = single;
		sts.scan_done   = (idx_q == used_q) && !sv_q;
		sts.pass        = pass_q;
		sts.code_last   = (idx_q == leaf_q);
		sts.leaf_last   = (10'(idx_q) + 10'd1) == 10'(leaf_q);
		sts.dec_to_leaf = (cmd.op == hbed_pkg::OP_DEC_STEP) && going_leaf;
	end

	// Memory ports.
	always_comb begin
		cnt_raddr = (cmd.op == hbed_pkg::OP_GATH) ? idx_q[SAW-1:0] : s;
		cnt_we    = (cmd.op == hbed_pkg::OP_CNT_WR) && out_free && sym_ok && !cnt_full;
		cnt_wdata = (cnt_vld_q[s] ? cnt_rdata : '0) + WW'(1);

		unique case (cmd.op)
			hbed_pkg::OP_DEC_RD, hbed_pkg::OP_DEC_STEP:  node_raddr = cur_eff;
			hbed_pkg::OP_DEC_LEAF, hbed_pkg::OP_DEC_FIN: node_raddr = next_q;
			default:                                     node_raddr = idx_q;
		endcase

		node_we    = 1'b0;
		node_waddr = used_q;
		node_wdata = '0;
		case (cmd.op)
			hbed_pkg::OP_GATH: begin
				node_we    = gath_hit;
				node_wdata = {1'b1, 9'd0, gidx_q, cnt_rdata};
			end
			hbed_pkg::OP_TAKE: begin
				node_we    = 1'b1;
				node_waddr = best_q;
				node_wdata = {1'b0, best_ch_q, best_w_q};
			end
			hbed_pkg::OP_MERGE: begin
				node_we    = 1'b1;
				node_wdata = {1'b1, best_q, a_q, a_w_q + best_w_q};
			end
			default: ;
		endcase

		nc_we    = 1'b0;
		nc_waddr = '0;
		nc_wdata = '0;
		case (cmd.op)
			hbed_pkg::OP_CSINGLE: begin
				nc_we    = 1'b1;
				nc_wdata = {32'd0, 6'd1};
			end
			hbed_pkg::OP_CROOT: begin
				nc_we    = 1'b1;
				nc_waddr = root_q;
			end
			hbed_pkg::OP_CWA: begin
				nc_we    = 1'b1;
				nc_waddr = node_rdata.left;
				nc_wdata = {nc_rdata.code << 1, nc_rdata.len + 6'd1};
			end
			hbed_pkg::OP_CWB: begin
				nc_we    = 1'b1;
				nc_waddr = node_rdata.right;
				nc_wdata = {(nc_rdata.code << 1) | 32'd1, nc_rdata.len + 6'd1};
			end
			default: ;
		endcase

		ct_we = (cmd.op == hbed_pkg::OP_LWR);
	end

	hbed_ram #(.W(WW), .D(A)) u_cnt_ram (
		.clk(clk), .we(cnt_we), .waddr(s), .wdata(cnt_wdata),
		.raddr(cnt_raddr), .rdata(cnt_rdata)
	);

	hbed_ram #(.W($bits(hbed_pkg::node_t)), .D(NN)) u_node_ram (
		.clk(clk), .we(node_we), .waddr(node_waddr[NAW-1:0]), .wdata(node_wdata),
		.raddr(node_raddr[NAW-1:0]), .rdata(node_rdata)
	);

	hbed_ram #(.W($bits(hbed_pkg::code_t)), .D(NN)) u_ncode_ram (
		.clk(clk), .we(nc_we), .waddr(nc_waddr[NAW-1:0]), .wdata(nc_wdata),
		.raddr(idx_q[NAW-1:0]), .rdata(nc_rdata)
	);

	hbed_ram #(.W($bits(hbed_pkg::code_t)), .D(A)) u_ctab_ram (
		.clk(clk), .we(ct_we), .waddr(node_rdata.left[SAW-1:0]), .wdata(nc_rdata),
		.raddr(s), .rdata(ct_rdata)
	);

	// Result formation for the ops that finish an item.
	always_comb begin
		res      = '0;
		res_load = 1'b0;
		case (cmd.op)
			hbed_pkg::OP_CNT_WR: begin
				res_load = 1'b1;
				if (!sym_ok) res.status = hbed_pkg::ST_NO_CODE;
				else if (cnt_full) res.status = hbed_pkg::ST_LIMIT;
			end
			hbed_pkg::OP_ENC_FIN: begin
				res_load = 1'b1;
				if (!tree_ready_q) begin
					res.status = hbed_pkg::ST_NO_TREE;
				end else if (!sym_ok || !code_vld_q[s] || ct_rdata.len == '0) begin
					res.status = hbed_pkg::ST_NO_CODE;
				end else begin
					res.code_word   = ct_rdata.code;
					res.code_length = ct_rdata.len;
				end
			end
			hbed_pkg::OP_DEC_STEP: begin
				res_load = !going_leaf;
				if (!tree_ready_q) begin
					res.status = hbed_pkg::ST_NO_TREE;
				end else if (single) begin
					res.decoded_symbol = node_rdata.left[7:0];
					res.symbol_valid   = 1'b1;
				end
			end
			hbed_pkg::OP_DEC_FIN: begin
				res_load           = 1'b1;
				res.decoded_symbol = node_rdata.left[7:0];
				res.symbol_valid   = 1'b1;
			end
			hbed_pkg::OP_CLR, hbed_pkg::OP_NOP: res_load = 1'b1;
			hbed_pkg::OP_B_EMPTY: begin
				res_load   = 1'b1;
				res.status = hbed_pkg::ST_NO_TREE;
			end
			hbed_pkg::OP_B_FIN: begin
				res_load              = 1'b1;
				res.distinct_symbols  = leaf_q;
				res.encoded_size_bits = sum_q;
			end
			default: ;
		endcase
		res_load = res_load && out_free;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) item_q <= in_data;
		if (res_load) out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q    <= '0;
			code_vld_q   <= '0;
			total_q      <= '0;
			tree_ready_q <= 1'b0;
			leaf_q       <= '0;
			root_q       <= '0;
			cursor_q     <= '0;
			used_q       <= '0;
			idx_q        <= '0;
			next_q       <= '0;
			gv_q         <= 1'b0;
			sv_q         <= 1'b0;
			found_q      <= 1'b0;
			pass_q       <= 1'b0;
			gidx_q       <= '0;
			sidx_q       <= '0;
			best_q       <= '0;
			a_q          <= '0;
			best_w_q     <= '0;
			a_w_q        <= '0;
			best_ch_q    <= '0;
			sum_q        <= '0;
			out_v_q      <= 1'b0;
		end else begin
			if (res_load) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;

			case (cmd.op)
				hbed_pkg::OP_CNT_WR: begin
					if (cnt_we) begin
						cnt_vld_q[s] <= 1'b1;
						total_q      <= total_q + WW'(1);
					end
				end
				hbed_pkg::OP_CLR: begin
					if (out_free) begin
						cnt_vld_q    <= '0;
						code_vld_q   <= '0;
						total_q      <= '0;
						tree_ready_q <= 1'b0;
						leaf_q       <= '0;
						root_q       <= '0;
						cursor_q     <= '0;
					end
				end
				hbed_pkg::OP_B_START: begin
					code_vld_q   <= '0;
					tree_ready_q <= 1'b0;
					leaf_q       <= '0;
					root_q       <= '0;
					cursor_q     <= '0;
					used_q       <= '0;
					idx_q        <= '0;
					gv_q         <= 1'b0;
					sum_q        <= '0;
				end
				hbed_pkg::OP_GATH: begin
					// Counts arrive in the cycle after their address; present leaves
					// are packed in ascending symbol order.
					gv_q   <= idx_q < 9'(A);
					gidx_q <= idx_q;
					if (idx_q < 9'(A)) idx_q <= idx_q + 9'd1;
					if (gath_hit) used_q <= used_q + 9'd1;
					if (sts.gath_done) leaf_q <= used_q;
				end
				hbed_pkg::OP_MCHK: begin
					idx_q   <= '0;
					sv_q    <= 1'b0;
					found_q <= 1'b0;
					pass_q  <= 1'b0;
					if (!sts.merge_more) root_q <= used_q - 9'd1;
				end
				hbed_pkg::OP_SCAN: begin
					sv_q   <= idx_q < used_q;
					sidx_q <= idx_q;
					if (idx_q < used_q) idx_q <= idx_q + 9'd1;
					// Strict compare keeps the lowest index on a weight tie.
					if (sv_q && node_rdata.live && (!found_q || node_rdata.weight < best_w_q)) begin
						best_q    <= sidx_q;
						best_w_q  <= node_rdata.weight;
						best_ch_q <= {node_rdata.right, node_rdata.left};
						found_q   <= 1'b1;
					end
				end
				hbed_pkg::OP_TAKE: begin
					if (!pass_q) begin
						a_q     <= best_q;
						a_w_q   <= best_w_q;
						pass_q  <= 1'b1;
						idx_q   <= '0;
						sv_q    <= 1'b0;
						found_q <= 1'b0;
					end
				end
				hbed_pkg::OP_MERGE: used_q <= used_q + 9'd1;
				hbed_pkg::OP_CSINGLE: idx_q <= '0;
				hbed_pkg::OP_CROOT: idx_q <= root_q;
				hbed_pkg::OP_CWB: begin
					if (idx_q == leaf_q) idx_q <= '0;
					else idx_q <= idx_q - 9'd1;
				end
				hbed_pkg::OP_LWR: begin
					code_vld_q[node_rdata.left[SAW-1:0]] <= 1'b1;
					sum_q <= sum_q + prod[hbed_pkg::SIZE_W-1:0];
					idx_q <= idx_q + 9'd1;
				end
				hbed_pkg::OP_B_FIN: begin
					if (out_free) begin
						tree_ready_q <= 1'b1;
						cursor_q     <= root_q;
					end
				end
				hbed_pkg::OP_DEC_STEP: begin
					next_q <= next;
					if (out_free && tree_ready_q && !single && !next_leaf) cursor_q <= next;
				end
				hbed_pkg::OP_DEC_FIN: begin
					if (out_free) cursor_q <= root_q;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

endmodule

[rtl/huffman_build_encode_decode.sv]
// Count and encode items pass a read and a finishing state, decode a read and a
// step state, plus a leaf and a finish state when a leaf is reached, clear and
// unused kinds a finishing state only; one item is in flight at a time, so the
// next is taken once the sequencer is back in idle. A build scans the alphabet
// once, then each of the n-1 merges makes two passes over the node memory, then
// codes are assigned and copied to the table; reset clears all via valid flags.
// ----------------------------------------------------------------------------
// huffman_build_encode_decode
// Static Huffman coder over a byte alphabet: frequency count, tree build,
// code table lookup and bit-serial tree-walk decoding.
// ----------------------------------------------------------------------------
module huffman_build_encode_decode #(
	parameter int ALPHABET_SIZE = hbed_pkg::ALPHABET_SIZE_DEF,
	parameter int MAX_TEXT_LEN  = hbed_pkg::MAX_TEXT_LEN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  hbed_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output hbed_pkg::out_t out_data
);

	hbed_pkg::cmd_t cmd;
	hbed_pkg::sts_t sts;

	hbed_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_kind(in_data.kind),
		.in_ready(in_ready), .sts(sts), .cmd(cmd)
	);

	hbed_dp #(
		.ALPHABET_SIZE(ALPHABET_SIZE),
		.MAX_TEXT_LEN(MAX_TEXT_LEN)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(in_data), .cmd(cmd), .sts(sts),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

endmodule

[test/huffman_build_encode_decode_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_build_encode_decode_test
// Checks the Huffman coder against a behavioral model kept in the bench:
// symbol counting, tree build with its tie rules, code lookup and bit-serial
// decoding, under random idling on both channels and a long output stall.
// ----------------------------------------------------------------------------
module huffman_build_encode_decode_test;

	localparam int ALPHA = 256;
	localparam int NODES = 2 * ALPHA - 1;
	localparam int TEXT_LIMIT = 65535;
	localparam longint CYCLE_LIMIT = 500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	hbed_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	hbed_pkg::out_t out_data;

	huffman_build_encode_decode uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

	// Coder state mirrored in the bench.
	int unsigned sym_count [ALPHA];
	int unsigned text_total;
	int unsigned nd_weight [NODES];
	int unsigned nd_left [NODES];
	int unsigned nd_right [NODES];
	int unsigned nd_sym [NODES];
	logic [31:0] tbl_code [ALPHA];
	int unsigned tbl_len [ALPHA];
	int unsigned root_node, walk_node, leaves;
	bit have_tree;

	hbed_pkg::in_t pending_items[$];
	hbed_pkg::out_t expected_results[$];
	int errors = 0;
	int builds_seen = 0, symbols_decoded = 0;
	int send_idle_pct = 0, recv_stall_pct = 0;
	bit hold_go = 1'b0;
	bit hold_active = 1'b0;
	longint cycle_count = 0;

	function automatic void coder_clear();
		for (int i = 0; i < ALPHA; i++) begin
			sym_count[i] = 0;
			tbl_code[i] = '0;
			tbl_len[i] = 0;
		end
		text_total = 0;
		root_node = 0;
		walk_node = 0;
		leaves = 0;
		have_tree = 0;
	endfunction

	function automatic int unsigned pick_lightest(ref bit live [NODES], input int unsigned used);
		int unsigned best;
		bit found;
		best = 0;
		found = 0;
		for (int unsigned i = 0; i < used; i++)
			if (live[i] && (!found || nd_weight[i] < nd_weight[best])) begin
				best = i;
				found = 1;
			end
		live[best] = 0;
		return best;
	endfunction

	function automatic void build_tree(output hbed_pkg::out_t r);
		bit live [NODES];
		logic [63:0] ncode [NODES];
		int unsigned nlen [NODES];
		int unsigned used, a, b, s;
		longint unsigned total_bits;
		r = '0;
		used = 0;
		total_bits = 0;
		for (int i = 0; i < ALPHA; i++) begin
			tbl_code[i] = '0;
			tbl_len[i] = 0;
		end
		have_tree = 0;
		leaves = 0;
		root_node = 0;
		walk_node = 0;
		if (text_total == 0) begin
			r.status = hbed_pkg::ST_NO_TREE;
			return;
		end
		for (int i = 0; i < NODES; i++) live[i] = 0;
		for (int unsigned k = 0; k < ALPHA; k++)
			if (sym_count[k] != 0) begin
				nd_weight[used] = sym_count[k];
				nd_sym[used] = k;
				live[used] = 1;
				used++;
			end
		leaves = used;
		for (int unsigned n = 1; n < leaves; n++) begin
			a = pick_lightest(live, used);
			b = pick_lightest(live, used);
			nd_weight[used] = (nd_weight[a] + nd_weight[b]) & 16'hFFFF;
			nd_left[used] = a;
			nd_right[used] = b;
			live[used] = 1;
			used++;
		end
		root_node = used - 1;
		if (leaves == 1) begin
			ncode[0] = '0;
			nlen[0] = 1;
		end else begin
			ncode[root_node] = '0;
			nlen[root_node] = 0;
			for (int n = int'(root_node); n >= int'(leaves); n--) begin
				ncode[nd_left[n]] = ncode[n] << 1;
				nlen[nd_left[n]] = nlen[n] + 1;
				ncode[nd_right[n]] = (ncode[n] << 1) | 64'd1;
				nlen[nd_right[n]] = nlen[n] + 1;
			end
		end
		for (int unsigned n = 0; n < leaves; n++) begin
			s = nd_sym[n];
			tbl_code[s] = ncode[n][31:0];
			tbl_len[s] = nlen[n];
			total_bits += longint'(sym_count[s]) * nlen[n];
		end
		walk_node = root_node;
		have_tree = 1;
		r.distinct_symbols = 9'(leaves);
		r.encoded_size_bits = total_bits[20:0];
	endfunction

	function automatic hbed_pkg::out_t coder_step(hbed_pkg::in_t it);
		hbed_pkg::out_t r;
		int unsigned nxt;
		r = '0;
		case (it.kind)
			hbed_pkg::KIND_COUNT: begin
				if (text_total >= TEXT_LIMIT) r.status = hbed_pkg::ST_LIMIT;
				else begin
					sym_count[it.symbol] = (sym_count[it.symbol] + 1) & 16'hFFFF;
					text_total++;
				end
			end
			hbed_pkg::KIND_BUILD: build_tree(r);
			hbed_pkg::KIND_ENCODE: begin
				if (!have_tree) r.status = hbed_pkg::ST_NO_TREE;
				else if (tbl_len[it.symbol] == 0) r.status = hbed_pkg::ST_NO_CODE;
				else begin
					r.code_word = tbl_code[it.symbol];
					r.code_length = 6'(tbl_len[it.symbol]);
				end
			end
			hbed_pkg::KIND_DECODE: begin
				if (!have_tree) r.status = hbed_pkg::ST_NO_TREE;
				else if (leaves == 1) begin
					r.decoded_symbol = 8'(nd_sym[0]);
					r.symbol_valid = 1'b1;
				end else begin
					if (walk_node < leaves) walk_node = root_node;
					nxt = it.coded_bit ? nd_right[walk_node] : nd_left[walk_node];
					if (nxt < leaves) begin
						r.decoded_symbol = 8'(nd_sym[nxt]);
						r.symbol_valid = 1'b1;
						walk_node = root_node;
					end else walk_node = nxt;
				end
			end
			hbed_pkg::KIND_CLEAR: coder_clear();
			default: ;
		endcase
		return r;
	endfunction

	function automatic void add_item(logic [2:0] k, logic [7:0] s, logic b);
		hbed_pkg::in_t it;
		it.kind = k;
		it.symbol = s;
		it.coded_bit = b;
		pending_items.insert(pending_items.size(), it);
	endfunction

	// Walks a code bit by bit as decode items, first bit first.
	function automatic void add_code_bits(logic [31:0] cw, int unsigned len);
		for (int i = int'(len) - 1; i >= 0; i--)
			add_item(hbed_pkg::KIND_DECODE, 8'($urandom), cw[i]);
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout at %0t", $time);
			$display("TB_ERROR");
			$finish;
		end
	end

	// Driver: the model is stepped when the item is accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_results.insert(expected_results.size(), coder_step(in_data));
				if (in_data.kind == hbed_pkg::KIND_BUILD) builds_seen++;
			end
			if (!(in_valid && !in_ready)) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_data <= pending_items.pop_front();
					in_valid <= 1'b1;
				end else in_valid <= 1'b0;
			end
		end
	end

	// Receiver hold-off: one long stall, counted in cycles here.
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_active <= 1'b1;
		repeat (300) @(posedge clk);
		hold_active <= 1'b0;
	end

	// Monitor.
	always @(posedge clk) begin
		hbed_pkg::out_t exp_r;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %h", $time, out_data);
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					if (out_data.symbol_valid) symbols_decoded++;
					if (out_data.status !== exp_r.status ||
							out_data.code_word !== exp_r.code_word ||
							out_data.code_length !== exp_r.code_length ||
							out_data.decoded_symbol !== exp_r.decoded_symbol ||
							out_data.symbol_valid !== exp_r.symbol_valid ||
							out_data.distinct_symbols !== exp_r.distinct_symbols ||
							out_data.encoded_size_bits !== exp_r.encoded_size_bits) begin
						$display("%0t: mismatch expected %h actual %h", $time, exp_r, out_data);
						errors++;
					end
				end
			end
			if (hold_active) out_ready <= 1'b0;
			else out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic drain();
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0 ||
				hold_active)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// A text of random length over a random subset of the alphabet, a build,
	// encodes of coded and uncoded symbols, and decodes of real code streams.
	task automatic text_round(int unsigned nsym, int unsigned nchars);
		logic [7:0] pool [];
		logic [7:0] s;
		pool = new[nsym];
		foreach (pool[i]) pool[i] = 8'($urandom);
		for (int i = 0; i < nchars; i++) begin
			s = ($urandom_range(3) == 0) ? pool[0] : pool[$urandom_range(nsym - 1)];
			add_item(hbed_pkg::KIND_COUNT, s, 1'($urandom));
		end
		add_item(hbed_pkg::KIND_BUILD, 8'($urandom), 1'($urandom));
		drain();
		for (int i = 0; i < 12; i++) begin
			s = ($urandom_range(4) == 0) ? 8'($urandom) : pool[$urandom_range(nsym - 1)];
			add_item(hbed_pkg::KIND_ENCODE, s, 1'($urandom));
			if (tbl_len[s] != 0) add_code_bits(tbl_code[s], tbl_len[s]);
		end
		for (int i = 0; i < 6; i++)
			add_item(hbed_pkg::KIND_DECODE, 8'($urandom), 1'($urandom));
		if ($urandom_range(2) == 0) add_item(hbed_pkg::KIND_CLEAR, 8'($urandom), 1'($urandom));
		else add_item(3'($urandom_range(7, 5)), 8'($urandom), 1'($urandom));
		drain();
	endtask

	initial begin
		coder_clear();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: no tree, empty build, single symbol, ties, extremes, unused kinds.
		add_item(hbed_pkg::KIND_ENCODE, 8'd0, 1'b0);
		add_item(hbed_pkg::KIND_DECODE, 8'hFF, 1'b1);
		add_item(hbed_pkg::KIND_BUILD, 8'd0, 1'b0);
		add_item(hbed_pkg::KIND_DECODE, 8'd0, 1'b0);
		add_item(hbed_pkg::KIND_COUNT, 8'hFF, 1'b1);
		add_item(hbed_pkg::KIND_COUNT, 8'hFF, 1'b0);
		add_item(hbed_pkg::KIND_BUILD, 8'd0, 1'b0);
		add_item(hbed_pkg::KIND_ENCODE, 8'hFF, 1'b0);
		add_item(hbed_pkg::KIND_ENCODE, 8'h00, 1'b0);
		add_item(hbed_pkg::KIND_DECODE, 8'd0, 1'b0);
		add_item(hbed_pkg::KIND_DECODE, 8'd0, 1'b1);
		add_item(hbed_pkg::KIND_COUNT, 8'h00, 1'b0);
		add_item(hbed_pkg::KIND_COUNT, 8'h55, 1'b0);
		add_item(hbed_pkg::KIND_COUNT, 8'hAA, 1'b0);
		add_item(hbed_pkg::KIND_ENCODE, 8'h00, 1'b0);
		add_item(hbed_pkg::KIND_BUILD, 8'd0, 1'b0);
		for (int i = 0; i < 4; i++) add_item(hbed_pkg::KIND_DECODE, 8'd0, i[0]);
		add_item(3'd5, 8'h12, 1'b1);
		add_item(3'd7, 8'hFF, 1'b0);
		add_item(hbed_pkg::KIND_CLEAR, 8'd0, 1'b0);
		add_item(hbed_pkg::KIND_ENCODE, 8'h55, 1'b0);
		drain();

		// Random phases with a mix of idling on each side.
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? 72 : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? 72 : 0;
			if (ph == 3) send_idle_pct = 12;
			if (ph == 3) recv_stall_pct = 12;
			for (int r = 0; r < 3; r++)
				text_round($urandom_range(1, (r == 2) ? 200 : 12), $urandom_range(1, 40));
		end

		// Long receiver hold-off while items keep coming, filling the block.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_go = 1'b1;
		text_round(6, 30);

		$display("Covered %0d builds and %0d decoded symbols over empty, single and mixed",
			builds_seen, symbols_decoded);
		$display("texts, with idling on both sides and one long output stall.");
		if (errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule
